>>> hdl/radar_report_frame_parser_top_defines.svh
// ----------------------------------------------------------------------------
// Radar report frame parser assertion macros
// Shared concurrent assertion forms for the frame parser.
// ----------------------------------------------------------------------------
`ifndef RADAR_REPORT_FRAME_PARSER_TOP_DEFINES_SVH
`define RADAR_REPORT_FRAME_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame parser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RRFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

`endif

>>> hdl/rrfp_pkg.sv
// ----------------------------------------------------------------------------
// Radar report frame parser package
// Types, frame constants and derived widths of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rrfp_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int POS_W       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

  localparam int HDR_LEN        = 4;
  localparam int REPORT_POS     = 12;
  localparam int GATE_FIRST_POS = 13;
  localparam int GATE_COUNT     = 9;
  localparam int GATE_LAST_POS  = GATE_FIRST_POS + 2 * GATE_COUNT - 1;
  localparam int GATE_W         = 5;
  localparam int ACK_FIELD_LEN  = 3;
  localparam int DETECT_POS     = 9;
  localparam int LAST_LAT0_POS  = 8;

  localparam logic [7:0] REPORT_HDR [HDR_LEN] = '{8'hF4, 8'hF3, 8'hF2, 8'hF1};
  localparam logic [7:0] ACK_HDR    [HDR_LEN] = '{8'hFD, 8'hFC, 8'hFB, 8'hFA};

  localparam logic [15:0] ACK_CLR_MASK = 16'h0100;
  localparam logic [7:0]  ENG_MODE     = 8'd1;

  localparam int         PADDR_W        = 3;
  localparam logic       REG_EXP_CMD    = 1'b0;
  localparam logic       REG_ACK_WAIT   = 1'b1;

  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_GATE   = 2'd1,
    KIND_ACK    = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       result_kind;
    logic [7:0]  report_mode;
    logic [7:0]  target_state;
    logic [15:0] moving_distance;
    logic [7:0]  moving_energy;
    logic [15:0] still_distance;
    logic [7:0]  still_energy;
    logic [15:0] detect_distance;
    logic [4:0]  gate_index;
    logic [7:0]  gate_energy;
    logic [15:0] ack_word;
    logic [7:0]  ack_status;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/radar_report_frame_parser_top.sv
// ----------------------------------------------------------------------------
// Radar report frame parser
// Byte-serial parser for report and acknowledge frames of a radar link.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  rx        in         rx_valid_i / rx_stall_o   rx_byte_i
//  res       out        res_valid_o / res_stall_i result fields, one port each
//  apb       in         psel, penable, pwrite     paddr, pwdata, prdata
//
//  One byte is taken per cycle while rx_stall_o is low; each byte updates
//  the parser state and any result it causes lands in the output stage.
//  A two-entry output stage (output register plus skid register) lets
//  bytes flow while a result waits; rx_stall_o rises only when both are full.
//  Reset clears the parser to header hunting and both registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radar_report_frame_parser_top_defines.svh"

module radar_report_frame_parser_top
  import rrfp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rx_valid_i,
  output logic                     rx_stall_o,
  input  wire logic [7:0]          rx_byte_i,
  output logic                     res_valid_o,
  input  wire logic                res_stall_i,
  output logic [1:0]               result_kind_o,
  output logic [7:0]               report_mode_o,
  output logic [7:0]               target_state_o,
  output logic [15:0]              moving_distance_o,
  output logic [7:0]               moving_energy_o,
  output logic [15:0]              still_distance_o,
  output logic [7:0]               still_energy_o,
  output logic [15:0]              detect_distance_o,
  output logic [4:0]               gate_index_o,
  output logic [7:0]               gate_energy_o,
  output logic [15:0]              ack_word_o,
  output logic [7:0]               ack_status_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LEN_LO  = 2'd1,
    PH_LEN_HI  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [2:0]        hm_q, hm_d;
  logic              is_ack_q, is_ack_d;
  logic [7:0]        len_lo_q, len_lo_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [63:0]       lat0_q, lat0_d;
  logic [15:0]       lat1_q, lat1_d;
  logic [15:0]       exp_cmd_q;
  logic              ack_wait_q;
  logic              out_valid_q, skid_valid_q;
  res_t              out_q, skid_q;

  logic              in_acc, drain, res_v, last, cfg_wr;
  res_t              res, rep_res, ack_res;
  logic [15:0]       full_len, ack_word;
  logic [7:0]        hdr_exp;
  logic [POS_W-1:0]  gate_off;
  logic              ack_ok, ack_end;

  assign rx_stall_o = skid_valid_q;
  assign in_acc     = rx_valid_i && !rx_stall_o;
  assign drain      = out_valid_q && !res_stall_i;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_EXP_CMD:  prdata = {16'd0, exp_cmd_q};
      REG_ACK_WAIT: prdata = {31'd0, ack_wait_q};
      default:      prdata = 32'd0;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    hm_d     = hm_q;
    is_ack_d = is_ack_q;
    len_lo_d = len_lo_q;
    len_d    = len_q;
    pos_d    = pos_q;
    lat0_d   = lat0_q;
    lat1_d   = lat1_q;
    res_v    = 1'b0;
    ack_end  = 1'b0;
    full_len = {rx_byte_i, len_lo_q};
    hdr_exp  = is_ack_q ? ACK_HDR[hm_q[1:0]] : REPORT_HDR[hm_q[1:0]];
    last     = (LEN_W'(pos_q) + LEN_W'(1)) == len_q;
    gate_off = pos_q - POS_W'(GATE_FIRST_POS);

    case (phase_q)
      PH_HUNT: begin
        if (hm_q != 3'd0 && hm_q < 3'(HDR_LEN) && rx_byte_i == hdr_exp) begin
          hm_d = hm_q + 3'd1;
          if (hm_d == 3'(HDR_LEN)) begin
            phase_d = PH_LEN_LO;
            hm_d    = 3'd0;
          end
        end else begin
          hm_d     = (rx_byte_i == REPORT_HDR[0] || rx_byte_i == ACK_HDR[0]) ? 3'd1 : 3'd0;
          is_ack_d = (rx_byte_i == ACK_HDR[0]);
        end
      end
      PH_LEN_LO: begin
        len_lo_d = rx_byte_i;
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        pos_d   = '0;
        lat0_d  = '0;
        lat1_d  = '0;
        len_d   = full_len[LEN_W-1:0];
        phase_d = PH_PAYLOAD;
        if (full_len > 16'(MAX_PAYLOAD) || full_len == 16'd0) begin
          phase_d  = PH_HUNT;
          hm_d     = 3'd0;
          is_ack_d = 1'b0;
          res_v    = (full_len == 16'd0) && !is_ack_q;
          ack_end  = (full_len == 16'd0) && is_ack_q;
        end
      end
      PH_PAYLOAD: begin
        for (int k = 0; k < 8; k++) begin
          if (is_ack_q ? (k < ACK_FIELD_LEN && pos_q == POS_W'(k))
                       : (k == 0 ? pos_q == '0
                                 : pos_q == POS_W'(k + 1))) begin
            lat0_d[8*k +: 8] = rx_byte_i;
          end
        end
        if (!is_ack_q && pos_q == POS_W'(DETECT_POS)) begin
          lat1_d[7:0] = rx_byte_i;
        end
        if (!is_ack_q && pos_q == POS_W'(DETECT_POS + 1)) begin
          lat1_d[15:8] = rx_byte_i;
        end
        if (is_ack_q) begin
          ack_end = last;
        end else if (pos_q == POS_W'(REPORT_POS)
                     || (pos_q < POS_W'(REPORT_POS) && last)) begin
          res_v = 1'b1;
        end else if (pos_q >= POS_W'(GATE_FIRST_POS) && pos_q <= POS_W'(GATE_LAST_POS)
                     && lat0_d[7:0] == ENG_MODE) begin
          res_v = 1'b1;
        end
        if (last) begin
          phase_d  = PH_HUNT;
          hm_d     = 3'd0;
          is_ack_d = 1'b0;
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end
      default: phase_d = PH_HUNT;
    endcase

    ack_word = lat0_d[15:0] & ~ACK_CLR_MASK;
    ack_ok   = ack_wait_q && ack_word == exp_cmd_q;
    if (ack_end && ack_ok) begin
      res_v = 1'b1;
    end

    rep_res                 = '0;
    rep_res.result_kind     = KIND_REPORT;
    rep_res.report_mode     = lat0_d[7:0];
    rep_res.target_state    = lat0_d[15:8];
    rep_res.moving_distance = lat0_d[31:16];
    rep_res.moving_energy   = lat0_d[39:32];
    rep_res.still_distance  = lat0_d[55:40];
    rep_res.still_energy    = lat0_d[63:56];
    rep_res.detect_distance = lat1_d;

    ack_res             = '0;
    ack_res.result_kind = KIND_ACK;
    ack_res.ack_word    = ack_word;
    ack_res.ack_status  = lat0_d[23:16];

    if (is_ack_q) begin
      res = ack_res;
    end else if (phase_q == PH_PAYLOAD && pos_q >= POS_W'(GATE_FIRST_POS)) begin
      res             = '0;
      res.result_kind = KIND_GATE;
      res.gate_index  = gate_off[GATE_W-1:0];
      res.gate_energy = rx_byte_i;
    end else begin
      res = rep_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      hm_q         <= 3'd0;
      is_ack_q     <= 1'b0;
      len_lo_q     <= 8'd0;
      len_q        <= '0;
      pos_q        <= '0;
      lat0_q       <= '0;
      lat1_q       <= '0;
      exp_cmd_q    <= 16'd0;
      ack_wait_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_EXP_CMD:  exp_cmd_q  <= pwdata[15:0];
          REG_ACK_WAIT: ack_wait_q <= pwdata[0];
          default:      ;
        endcase
      end
      if (in_acc) begin
        phase_q  <= phase_d;
        hm_q     <= hm_d;
        is_ack_q <= is_ack_d;
        len_lo_q <= len_lo_d;
        len_q    <= len_d;
        pos_q    <= pos_d;
        lat0_q   <= lat0_d;
        lat1_q   <= lat1_d;
      end
      if (!out_valid_q || drain) begin
        if (skid_valid_q) begin
          out_q        <= skid_q;
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_q       <= res;
          out_valid_q <= in_acc && res_v;
        end
      end else if (in_acc && res_v) begin
        skid_q       <= res;
        skid_valid_q <= 1'b1;
      end
    end
  end

  assign res_valid_o       = out_valid_q;
  assign result_kind_o     = out_q.result_kind;
  assign report_mode_o     = out_q.report_mode;
  assign target_state_o    = out_q.target_state;
  assign moving_distance_o = out_q.moving_distance;
  assign moving_energy_o   = out_q.moving_energy;
  assign still_distance_o  = out_q.still_distance;
  assign still_energy_o    = out_q.still_energy;
  assign detect_distance_o = out_q.detect_distance;
  assign gate_index_o      = out_q.gate_index;
  assign gate_energy_o     = out_q.gate_energy;
  assign ack_word_o        = out_q.ack_word;
  assign ack_status_o      = out_q.ack_status;

  `RRFP_ASSERT_SAME(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `RRFP_ASSERT_SAME(a_pos_in_frame, clk_i, rst_ni, phase_q == PH_PAYLOAD,
                    LEN_W'(pos_q) < len_q)
  `RRFP_ASSERT_NEXT(a_blocked_result_kept, clk_i, rst_ni,
                    in_acc && res_v && out_valid_q && res_stall_i, skid_valid_q)
  `RRFP_ASSERT_SAME(a_gate_index_range, clk_i, rst_ni,
                    out_valid_q && out_q.result_kind == KIND_GATE,
                    out_q.gate_index <= 5'(2 * GATE_COUNT - 1))

endmodule

`default_nettype wire

>>> verif/radar_report_frame_parser_top_tb.sv
// ----------------------------------------------------------------------------
// Radar report frame parser testbench
// Streams report, acknowledge, oversized, broken and noise frames into the
// parser with random gaps and result stalls, predicts every result with a
// behavioural copy of the parser and checks each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module radar_report_frame_parser_top_tb;
  import rrfp_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY
  } parse_ph_e;

  localparam logic [PADDR_W-1:0] ADDR_EXP_CMD  = PADDR_W'(4 * int'(REG_EXP_CMD));
  localparam logic [PADDR_W-1:0] ADDR_ACK_WAIT = PADDR_W'(4 * int'(REG_ACK_WAIT));
  localparam int PHASE_BYTES = 225;
  localparam int NUM_SETTINGS = 6;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                rx_valid_i = 1'b0;
  logic                rx_stall_o;
  logic [7:0]          rx_byte_i = 8'h00;
  logic                res_valid_o;
  logic                res_stall_i = 1'b0;
  logic [1:0]          result_kind_o;
  logic [7:0]          report_mode_o;
  logic [7:0]          target_state_o;
  logic [15:0]         moving_distance_o;
  logic [7:0]          moving_energy_o;
  logic [15:0]         still_distance_o;
  logic [7:0]          still_energy_o;
  logic [15:0]         detect_distance_o;
  logic [4:0]          gate_index_o;
  logic [7:0]          gate_energy_o;
  logic [15:0]         ack_word_o;
  logic [7:0]          ack_status_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  radar_report_frame_parser_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rx_valid_i        (rx_valid_i),
    .rx_stall_o        (rx_stall_o),
    .rx_byte_i         (rx_byte_i),
    .res_valid_o       (res_valid_o),
    .res_stall_i       (res_stall_i),
    .result_kind_o     (result_kind_o),
    .report_mode_o     (report_mode_o),
    .target_state_o    (target_state_o),
    .moving_distance_o (moving_distance_o),
    .moving_energy_o   (moving_energy_o),
    .still_distance_o  (still_distance_o),
    .still_energy_o    (still_energy_o),
    .detect_distance_o (detect_distance_o),
    .gate_index_o      (gate_index_o),
    .gate_energy_o     (gate_energy_o),
    .ack_word_o        (ack_word_o),
    .ack_status_o      (ack_status_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Parser copy used to work out the awaited results.
  logic [15:0] cfg_expected_cmd = '0;
  logic        cfg_ack_wait = 1'b0;
  logic [2:0]  hunt_count = '0;
  logic        in_ack_frame = 1'b0;
  parse_ph_e   parse_ph = PH_HUNT;
  logic [15:0] frame_len = '0;
  logic [15:0] body_pos = '0;
  logic [63:0] latch_lo = '0;
  logic [63:0] latch_hi = '0;

  res_t        awaited_results[$];
  logic [7:0]  rx_bytes_pending[$];

  int fail_count = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int num_reports = 0;
  int num_gates = 0;
  int num_acks = 0;
  int settings_applied = 0;

  logic rx_fire = 1'b0;
  int   rx_gap_left = 0;
  int   rx_burst_left = 0;
  int   stall_left = 0;
  int   stall_burst_left = 0;

  function automatic void restart_hunt(input logic [7:0] b);
    parse_ph = PH_HUNT;
    if (b == REPORT_HDR[0]) begin
      hunt_count = 3'd1;
      in_ack_frame = 1'b0;
    end else if (b == ACK_HDR[0]) begin
      hunt_count = 3'd1;
      in_ack_frame = 1'b1;
    end else begin
      hunt_count = 3'd0;
      in_ack_frame = 1'b0;
    end
  endfunction

  function automatic void await_report();
    res_t r;
    r = '0;
    r.result_kind     = KIND_REPORT;
    r.report_mode     = latch_lo[7:0];
    r.target_state    = latch_lo[15:8];
    r.moving_distance = latch_lo[31:16];
    r.moving_energy   = latch_lo[39:32];
    r.still_distance  = latch_lo[55:40];
    r.still_energy    = latch_lo[63:56];
    r.detect_distance = latch_hi[15:0];
    awaited_results.push_back(r);
  endfunction

  function automatic void await_ack();
    res_t        r;
    logic [15:0] word;
    word = latch_lo[15:0] & ~ACK_CLR_MASK;
    if (cfg_ack_wait && word == cfg_expected_cmd) begin
      r = '0;
      r.result_kind = KIND_ACK;
      r.ack_word    = word;
      r.ack_status  = latch_lo[23:16];
      awaited_results.push_back(r);
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    res_t r;
    logic last;
    int   p;
    logic [7:0] want;
    case (parse_ph)
      PH_HUNT: begin
        want = in_ack_frame ? ACK_HDR[hunt_count[1:0]] : REPORT_HDR[hunt_count[1:0]];
        if (hunt_count > 0 && hunt_count < HDR_LEN && b == want) begin
          hunt_count = hunt_count + 3'd1;
          if (hunt_count == HDR_LEN) begin
            parse_ph = PH_LEN_LO;
            hunt_count = '0;
          end
        end else begin
          restart_hunt(b);
        end
      end
      PH_LEN_LO: begin
        frame_len = {8'h00, b};
        parse_ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_len[15:8] = b;
        body_pos = '0;
        latch_lo = '0;
        latch_hi = '0;
        if (frame_len > MAX_PAYLOAD) begin
          restart_hunt(8'h00);
        end else if (frame_len == 0) begin
          if (in_ack_frame) await_ack();
          else await_report();
          restart_hunt(8'h00);
        end else begin
          parse_ph = PH_BODY;
        end
      end
      default: begin
        p = int'(body_pos);
        last = (p + 1 >= int'(frame_len));
        if (in_ack_frame) begin
          if (p < ACK_FIELD_LEN) latch_lo[p*8 +: 8] = b;
          if (last) begin
            await_ack();
            restart_hunt(8'h00);
          end else begin
            body_pos = body_pos + 16'd1;
          end
        end else begin
          if (p == 0) latch_lo[7:0] = b;
          else if (p >= 2 && p <= LAST_LAT0_POS) latch_lo[(p-1)*8 +: 8] = b;
          else if (p == DETECT_POS || p == DETECT_POS + 1) latch_hi[(p-DETECT_POS)*8 +: 8] = b;
          if (p == REPORT_POS || (p < REPORT_POS && last)) begin
            await_report();
          end else if (p >= GATE_FIRST_POS && p <= GATE_LAST_POS &&
                       latch_lo[7:0] == ENG_MODE) begin
            r = '0;
            r.result_kind = KIND_GATE;
            r.gate_index  = GATE_W'(p - GATE_FIRST_POS);
            r.gate_energy = b;
            awaited_results.push_back(r);
          end
          if (last) restart_hunt(8'h00);
          else body_pos = body_pos + 16'd1;
        end
      end
    endcase
  endfunction

  function automatic int pause_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Byte side: acceptance and prediction on the rising edge.
  always @(posedge clk_i) begin
    rx_fire = rst_ni && rx_valid_i && !rx_stall_o;
    if (rx_fire) begin
      parse_byte(rx_byte_i);
      bytes_taken++;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rx_valid_i <= 1'b0;
    end else if (rx_valid_i && !rx_fire) begin
      rx_valid_i <= 1'b1;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      rx_valid_i <= 1'b0;
    end else if (rx_bytes_pending.size() != 0) begin
      rx_byte_i <= rx_bytes_pending.pop_front();
      rx_valid_i <= 1'b1;
      if (rx_burst_left > 0) begin
        rx_burst_left--;
        rx_gap_left = 0;
      end else begin
        if ($urandom_range(0, 99) == 0) rx_burst_left = $urandom_range(20, 80);
        rx_gap_left = pause_len();
      end
    end else begin
      rx_valid_i <= 1'b0;
    end
  end

  // Result side: stall generation and checking.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= 1'b0;
      if (stall_burst_left > 0) begin
        stall_burst_left--;
      end else begin
        if ($urandom_range(0, 99) == 0) stall_burst_left = $urandom_range(20, 80);
        stall_left = pause_len();
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (awaited_results.size() == 0) begin
        fail_count++;
        $display("%0t: result kind %0d with no transaction awaited, expected none, actual %h",
                 $time, result_kind_o, result_kind_o);
      end else begin
        want = awaited_results.pop_front();
        case (want.result_kind)
          KIND_REPORT: num_reports++;
          KIND_GATE:   num_gates++;
          default:     num_acks++;
        endcase
        check_field("result_kind", 16'(want.result_kind), 16'(result_kind_o));
        check_field("report_mode", 16'(want.report_mode), 16'(report_mode_o));
        check_field("target_state", 16'(want.target_state), 16'(target_state_o));
        check_field("moving_distance", want.moving_distance, moving_distance_o);
        check_field("moving_energy", 16'(want.moving_energy), 16'(moving_energy_o));
        check_field("still_distance", want.still_distance, still_distance_o);
        check_field("still_energy", 16'(want.still_energy), 16'(still_energy_o));
        check_field("detect_distance", want.detect_distance, detect_distance_o);
        check_field("gate_index", 16'(want.gate_index), 16'(gate_index_o));
        check_field("gate_energy", 16'(want.gate_energy), 16'(gate_energy_o));
        check_field("ack_word", want.ack_word, ack_word_o);
        check_field("ack_status", 16'(want.ack_status), 16'(ack_status_o));
      end
    end
  end

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] cmd, input logic en);
    reg_write(ADDR_EXP_CMD, {16'($urandom), cmd});
    cfg_expected_cmd = cmd;
    reg_write(ADDR_ACK_WAIT, {31'($urandom), en});
    cfg_ack_wait = en;
    settings_applied++;
  endtask

  task automatic wait_idle();
    while (rx_bytes_pending.size() != 0 || rx_valid_i || awaited_results.size() != 0 ||
           res_valid_o)
      @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic void push_byte(input logic [7:0] b);
    rx_bytes_pending.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void push_header(input logic is_ack);
    for (int i = 0; i < HDR_LEN; i++)
      push_byte(is_ack ? ACK_HDR[i] : REPORT_HDR[i]);
  endfunction

  function automatic void push_len(input logic [15:0] len);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
  endfunction

  function automatic void push_report(input logic [7:0] mode, input int len,
                                      input logic tail);
    push_header(1'b0);
    push_len(16'(len));
    for (int i = 0; i < len; i++)
      push_byte(i == 0 ? mode : 8'($urandom));
    if (tail) begin
      push_byte(8'hF8);
      push_byte(8'hF7);
      push_byte(8'hF6);
      push_byte(8'hF5);
    end
  endfunction

  function automatic void push_ack(input logic [15:0] word, input logic [7:0] status,
                                   input int len);
    push_header(1'b1);
    push_len(16'(len));
    for (int i = 0; i < len; i++) begin
      case (i)
        0:       push_byte(word[7:0]);
        1:       push_byte(word[15:8]);
        2:       push_byte(status);
        default: push_byte(8'($urandom));
      endcase
    end
    push_byte(8'h04);
    push_byte(8'h03);
    push_byte(8'h02);
    push_byte(8'h01);
  endfunction

  function automatic void push_random_frame();
    int          pick;
    int          n;
    logic        is_ack;
    logic [15:0] word;
    logic [7:0]  mode;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      mode = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd2;
      n = ($urandom_range(0, 1) == 0) ? REPORT_POS + 1 : $urandom_range(0, 20);
      push_report(mode, n, $urandom_range(0, 9) < 7);
    end else if (pick < 60) begin
      n = ($urandom_range(0, 1) == 0) ? 35 : $urandom_range(GATE_FIRST_POS, MAX_PAYLOAD);
      push_report(ENG_MODE, n, $urandom_range(0, 9) < 7);
    end else if (pick < 80) begin
      if ($urandom_range(0, 99) < 75)
        word = cfg_expected_cmd | (16'($urandom_range(0, 1)) << 8);
      else
        word = 16'($urandom);
      n = ($urandom_range(0, 9) < 6) ? 4 : $urandom_range(0, 8);
      push_ack(word, ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom), n);
    end else if (pick < 86) begin
      push_header(1'($urandom_range(0, 1)));
      case ($urandom_range(0, 2))
        0:       push_len(16'(MAX_PAYLOAD + 1));
        1:       push_len(16'hFFFF);
        default: push_len(16'($urandom_range(MAX_PAYLOAD + 1, 65535)));
      endcase
    end else if (pick < 93) begin
      is_ack = 1'($urandom_range(0, 1));
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        push_byte(is_ack ? ACK_HDR[i] : REPORT_HDR[i]);
      case ($urandom_range(0, 2))
        0:       push_byte(8'($urandom));
        1:       push_byte(ACK_HDR[0]);
        default: push_byte(REPORT_HDR[0]);
      endcase
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        push_byte(8'($urandom));
    end
  endfunction

  initial begin
    logic [15:0] set_cmd [NUM_SETTINGS];
    logic        set_en  [NUM_SETTINGS];
    int          phase_start;
    set_cmd[0] = 16'h0000;                          set_en[0] = 1'b1;
    set_cmd[1] = 16'hFFFF;                          set_en[1] = 1'b1;
    set_cmd[2] = 16'h0061;                          set_en[2] = 1'b1;
    set_cmd[3] = 16'hFEFF;                          set_en[3] = 1'b1;
    set_cmd[4] = 16'($urandom);                     set_en[4] = 1'b0;
    set_cmd[5] = 16'($urandom) & ~ACK_CLR_MASK;     set_en[5] = 1'b1;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset settings.
    push_header(1'b0);
    push_len(16'h0000);
    push_byte(REPORT_HDR[0]);
    push_byte(REPORT_HDR[1]);
    push_header(1'b1);
    push_len(16'h0000);
    push_header(1'b0);
    push_len(16'(MAX_PAYLOAD + 1));
    push_byte(8'h00);
    push_byte(8'hFF);
    push_report(ENG_MODE, 3, 1'b0);
    wait_idle();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      apply_setting(set_cmd[s], set_en[s]);
      phase_start = bytes_queued;
      if (s == 0) push_ack(16'h0000, 8'h00, 0);
      while (bytes_queued - phase_start < PHASE_BYTES)
        push_random_frame();
      wait_idle();
    end

    $display("covered %0d bytes over %0d register settings", bytes_taken, settings_applied);
    $display("results checked: %0d reports, %0d gate energies, %0d acknowledges",
             num_reports, num_gates, num_acks);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/rrfp_pkg.sv
hdl/radar_report_frame_parser_top.sv
verif/radar_report_frame_parser_top_tb.sv
